@@ hdl/bwsd_pkg.sv @@
package bwsd_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_STEAL  = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] task_handle;
    logic [31:0] task_generation;
  } slot_t;

endpackage

@@ hdl/bwsd_if.sv @@
interface bwsd_req_if;
  import bwsd_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] task_handle;
  logic [31:0] task_generation;
  modport source (output valid, action, task_handle, task_generation, input ready);
  modport sink   (input valid, action, task_handle, task_generation, output ready);
endinterface

interface bwsd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] task_out;
  logic [31:0] generation_out;
  logic [6:0]  count;
  logic        is_empty;
  modport source (output valid, status, task_out, generation_out, count, is_empty,
                  input ready);
  modport sink   (input valid, status, task_out, generation_out, count, is_empty,
                  output ready);
endinterface

@@ hdl/bwsd_cell.sv @@
// One ring slot. The whole ring rotates one place per cycle while shift_i is high
// (shift toward lower index), so the slot at position 0 is the one the sequencer sees.
module bwsd_cell
  import bwsd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  load_i,
  input  slot_t load_data_i,
  input  slot_t neighbor_i,
  output slot_t slot_o
);
  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (load_i) begin
      slot_q <= load_data_i;
    end else if (shift_i) begin
      slot_q <= neighbor_i;
    end
  end

  assign slot_o = slot_q;
endmodule

@@ hdl/bounded_work_stealing_deque_core.sv @@
// Bounded work-stealing deque of CAPACITY task slots held in a row of
// cells that rotates as a ring, one position per cycle while aligning
// and only forward. A physical rotation offset tracks which slot sits at
// cell 0; the sequencer only ever reads and writes cell 0. Each request
// that needs a slot first aligns the ring to its target slot, shifting
// until the offset matches, then works on the slot itself. Steal and
// remove step forward one slot at a time. Pop steps backward, so every
// further slot costs a near-full rotation of the ring. A pop, steal or
// remove on an empty range, a remove of the null handle and a push into
// a full deque answer without aligning the ring. The result is held in
// an output register until taken, and no new request is accepted before
// then.
module bounded_work_stealing_deque_core
  import bwsd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic clk_i,
  input logic rst_ni,
  bwsd_req_if.sink   req_i,
  bwsd_rsp_if.source rsp_o
);
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = SW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_WORK  = 3'd2;
  localparam logic [2:0] S_RESP  = 3'd3;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] bot_q, bot_d, top_q, top_d, ptr_q, ptr_d;
  logic [SW-1:0] rot_q, rot_d;
  logic [1:0]    act_q, act_d;
  logic [31:0]   hnd_q, hnd_d, gen_q, gen_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   tout_q, tout_d, gout_q, gout_d;

  slot_t cells [CAPACITY];
  logic  shift, load;
  slot_t load_data;

  // ring of cells, each cell receives from the next, the last cell from cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bwsd_cell u_cell (
      .clk_i, .rst_ni,
      .shift_i    (shift),
      .load_i     (load && (i == 0)),
      .load_data_i(load_data),
      .neighbor_i (cells[(i + 1) % CAPACITY]),
      .slot_o     (cells[i])
    );
  end

  logic [IW-1:0] live;
  assign live = bot_q - top_q;
  logic [SW-1:0] tgt;
  assign tgt = ptr_q[SW-1:0];

  always_comb begin
    state_d = state_q; bot_d = bot_q; top_d = top_q; ptr_d = ptr_q;
    rot_d = rot_q; act_d = act_q; hnd_d = hnd_q; gen_d = gen_q;
    st_d = st_q; tout_d = tout_q; gout_d = gout_q;
    shift = 1'b0; load = 1'b0; load_data = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d = req_i.action; hnd_d = req_i.task_handle;
          gen_d = req_i.task_generation;
          st_d = ST_EMPTY; tout_d = '0; gout_d = '0;
          state_d = S_ALIGN;
          unique case (action_e'(req_i.action))
            ACT_PUSH: begin
              ptr_d = bot_q;
              if (live >= IW'(CAPACITY)) begin
                st_d = ST_FULL; state_d = S_RESP;
              end
            end
            ACT_POP: begin
              ptr_d = bot_q - 1'b1;
              if (bot_q == top_q) state_d = S_RESP;
            end
            ACT_STEAL, ACT_REMOVE: begin
              ptr_d = top_q;
              if (bot_q == top_q ||
                  (req_i.action == ACT_REMOVE && req_i.task_handle == '0))
                state_d = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_ALIGN: begin
        if (rot_q == tgt) begin
          state_d = S_WORK;
        end else begin
          shift = 1'b1; rot_d = rot_q + 1'b1;
        end
      end
      S_WORK: begin
        unique case (action_e'(act_q))
          ACT_PUSH: begin
            load = 1'b1; load_data = '{hnd_q, gen_q};
            bot_d = bot_q + 1'b1; st_d = ST_DONE; state_d = S_RESP;
          end
          ACT_POP: begin
            load = 1'b1;
            bot_d = bot_q - 1'b1;
            if (cells[0].task_handle != '0) begin
              st_d = ST_DONE; tout_d = cells[0].task_handle;
              gout_d = cells[0].task_generation; state_d = S_RESP;
            end else if (bot_q - 1'b1 == top_q) begin
              state_d = S_RESP;
            end else begin
              ptr_d = ptr_q - 1'b1; state_d = S_ALIGN;
            end
          end
          ACT_STEAL: begin
            load = 1'b1;
            top_d = top_q + 1'b1;
            if (cells[0].task_handle != '0) begin
              st_d = ST_DONE; tout_d = cells[0].task_handle;
              gout_d = cells[0].task_generation; state_d = S_RESP;
            end else if (top_q + 1'b1 == bot_q) begin
              state_d = S_RESP;
            end else begin
              ptr_d = ptr_q + 1'b1; state_d = S_ALIGN;
            end
          end
          ACT_REMOVE: begin
            if (cells[0].task_handle == hnd_q) begin
              load = 1'b1; st_d = ST_DONE; state_d = S_RESP;
            end else if (ptr_q + 1'b1 == bot_q) begin
              state_d = S_RESP;
            end else begin
              ptr_d = ptr_q + 1'b1; state_d = S_ALIGN;
            end
          end
          default: ;
        endcase
      end
      S_RESP: begin
        if (rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; bot_q <= '0; top_q <= '0; ptr_q <= '0; rot_q <= '0;
    end else begin
      state_q <= state_d; bot_q <= bot_d; top_q <= top_d; ptr_q <= ptr_d;
      rot_q <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; hnd_q <= hnd_d; gen_q <= gen_d; st_q <= st_d;
    tout_q <= tout_d; gout_q <= gout_d;
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_RESP);
  assign rsp_o.status         = st_q;
  assign rsp_o.task_out       = tout_q;
  assign rsp_o.generation_out = gout_q;
  assign rsp_o.count          = 7'(live);
  assign rsp_o.is_empty       = (bot_q == top_q);
endmodule
